// ----- hw/rtl/decaying_sine_beep_generator_defines.svh -----
// ----------------------------------------------------------------------------
// Decaying sine beep generator: assertion macros
// Shared wrappers for the concurrent assertions of the block's checker.
// ----------------------------------------------------------------------------
`ifndef DECAYING_SINE_BEEP_GENERATOR_DEFINES_SVH
`define DECAYING_SINE_BEEP_GENERATOR_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define DSB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DSB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/dsb_pkg.sv -----
// ----------------------------------------------------------------------------
// Decaying sine beep generator package
// Widths, constants, register indexes and shared types of the beep block.
// ----------------------------------------------------------------------------
package dsb_pkg;

   localparam int FRAME_W     = 20;
   localparam int PHASE_W     = 32;
   localparam int SAMPLE_W    = 16;
   localparam int MAG_W       = 15;
   localparam int AMP_W       = 30;
   localparam int PROD_W      = AMP_W + FRAME_W;
   localparam int NUM_W       = PROD_W - 16;
   localparam int QUOT_W      = 14;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 32'd42852281;
   localparam logic [FRAME_W-1:0] LENGTH_RESET     = 20'd8820;

   // 0.3 of full scale in Q16.
   localparam logic [MAG_W-1:0] AMP_Q16 = 15'd19661;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned FULL_Q15    = 64'd32767;
   localparam longint unsigned ROUND_Q30   = 64'd536870912;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PHASE_STEP    = 1'b0,
      CSR_LENGTH_FRAMES = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_MUL_AMP,
      ST_MUL_ENV,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sine_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- hw/rtl/dsb_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Builds the Q1.15 quarter-wave table at elaboration and looks up the sine of
// a 32-bit phase with quadrant folding; the result is registered.
// ----------------------------------------------------------------------------
module dsb_sine_rom #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                         clock,
   input  logic [dsb_pkg::PHASE_W-1:0]  phase,
   output dsb_pkg::sine_type            sine
);
   import dsb_pkg::*;

   localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

   logic [MAG_W-1:0]      rom_table [0:SINE_TABLE_DEPTH];
   logic [29+IDX_W:0]     scaled;
   logic [IDX_W-1:0]      idx;
   logic [IDX_W-1:0]      addr;
   sine_type              sine_ff;
   sine_type              sine_in;

   // Each entry is an eleven-term Taylor series in Q30, truncated at every term.
   for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_entry
      localparam longint unsigned X   = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      localparam longint unsigned X2  = (X * X) >> 30;
      localparam longint unsigned T1  = ((X * X2) >> 30) / 6;
      localparam longint unsigned T2  = ((T1 * X2) >> 30) / 20;
      localparam longint unsigned T3  = ((T2 * X2) >> 30) / 42;
      localparam longint unsigned T4  = ((T3 * X2) >> 30) / 72;
      localparam longint unsigned T5  = ((T4 * X2) >> 30) / 110;
      localparam longint unsigned T6  = ((T5 * X2) >> 30) / 156;
      localparam longint unsigned T7  = ((T6 * X2) >> 30) / 210;
      localparam longint unsigned T8  = ((T7 * X2) >> 30) / 272;
      localparam longint unsigned T9  = ((T8 * X2) >> 30) / 342;
      localparam longint unsigned T10 = ((T9 * X2) >> 30) / 420;
      localparam longint S = longint'(X) - longint'(T1) + longint'(T2) - longint'(T3)
                           + longint'(T4) - longint'(T5) + longint'(T6) - longint'(T7)
                           + longint'(T8) - longint'(T9) + longint'(T10);
      localparam longint SC = (S < 0) ? 64'sd0 : S;
      localparam longint unsigned V  = (unsigned'(SC) * FULL_Q15 + ROUND_Q30) >> 30;
      localparam longint unsigned VC = (V > FULL_Q15) ? FULL_Q15 : V;
      assign rom_table[k] = MAG_W'(VC);
   end

   assign scaled = {{IDX_W{1'b0}}, phase[29:0]} * (30 + IDX_W)'(SINE_TABLE_DEPTH);
   assign idx    = scaled[29+IDX_W:30];

   always_comb begin
      // Odd quadrants run the table backwards, the second half-turn is negated.
      addr = phase[30] ? IDX_W'(SINE_TABLE_DEPTH) - idx : idx;
      sine_in.neg = phase[31];
      sine_in.mag = rom_table[addr];
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
   end

   assign sine = sine_ff;

endmodule

// ----- hw/rtl/dsb_divider.sv -----
// ----------------------------------------------------------------------------
// Envelope divider
// Restoring divider that produces one quotient bit per cycle with a single
// shared compare and subtract.
// ----------------------------------------------------------------------------
module dsb_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dsb_pkg::NUM_W-1:0]   numerator,
   input  logic [dsb_pkg::FRAME_W-1:0] divisor,
   output dsb_pkg::div_status_type     status,
   output logic [dsb_pkg::QUOT_W-1:0]  quotient
);
   import dsb_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [FRAME_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]    shift_ff, shift_in;
   logic [FRAME_W:0]     trial;
   logic [FRAME_W:0]     diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      trial    = {rem_ff, shift_ff[QUOT_W-1]};
      diff     = trial - {1'b0, divisor};
      if (start) begin
         // The quotient is known to fit, so the top part is already below the divisor.
         busy_in  = 1'b1;
         count_in = CNT_W'(QUOT_W);
         rem_in   = numerator[NUM_W-1:QUOT_W];
         shift_in = numerator[QUOT_W-1:0];
      end else if (busy_ff) begin
         if (!diff[FRAME_W]) begin
            rem_in   = diff[FRAME_W-1:0];
            shift_in = {shift_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in   = trial[FRAME_W-1:0];
            shift_in = {shift_ff[QUOT_W-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = shift_ff;

endmodule

// ----- hw/rtl/decaying_sine_beep_generator.sv -----
// ----------------------------------------------------------------------------
// Decaying sine beep generator
// Produces one 16-bit sample of a 0.3 full-scale sine tone under a linear
// decay envelope for every tick transfer while a tone plays.
// ----------------------------------------------------------------------------
// A tick with start_req set restarts the tone at frame zero and phase zero;
// ticks while no tone plays are absorbed at once and give no result. During
// a tone the block is busy after a tick's transfer and takes the next tick
// only once it has run a registered table lookup, two multiplications, a
// divider start, and a 14-step restoring divider that forms the envelope one
// quotient bit per cycle and then reports its result, and has handed the
// sample over. The finished sample sits in an output register, so a new
// tick is taken while it waits to be read; a tick only takes longer when the
// previous sample is still unread by the time the next one is finished. The
// final sample of a tone carries last.
module decaying_sine_beep_generator #(
   parameter int SINE_TABLE_DEPTH = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_start_req,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [dsb_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dsb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [dsb_pkg::CSR_DATA_W-1:0]  csr_data
);
   import dsb_pkg::*;

   state_type               state_ff, state_in;
   logic [PHASE_W-1:0]      step_ff, step_in;
   logic [FRAME_W-1:0]      length_ff, length_in;
   logic [FRAME_W-1:0]      frame_ff, frame_in;
   logic [PHASE_W-1:0]      phase_ff, phase_in;
   logic                    active_ff, active_in;
   logic [FRAME_W-1:0]      len_ff, len_in;
   logic [FRAME_W-1:0]      remain_ff, remain_in;
   logic                    last_ff, last_in;
   logic [AMP_W-1:0]        amp_ff, amp_in;
   logic                    neg_ff, neg_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]     rsp_sample_ff, rsp_sample_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [PROD_W-1:0]       product;
   logic                    div_start;
   logic                    out_free;
   sine_type                sine;
   div_status_type          div_status;
   logic [QUOT_W-1:0]       quotient;

   dsb_sine_rom #(
      .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
   ) u_rom (
      .clock (clock),
      .phase (phase_ff),
      .sine  (sine)
   );

   dsb_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (num_ff),
      .divisor   (len_ff),
      .status    (div_status),
      .quotient  (quotient)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign product  = {{FRAME_W{1'b0}}, amp_ff} * {{AMP_W{1'b0}}, remain_ff};

   // Register writes.
   always_comb begin
      step_in   = step_ff;
      length_in = length_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PHASE_STEP:    step_in   = csr_data;
            CSR_LENGTH_FRAMES: length_in = csr_data[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      frame_in      = frame_ff;
      phase_in      = phase_ff;
      active_in     = active_ff;
      len_in        = len_ff;
      remain_in     = remain_ff;
      last_in       = last_ff;
      amp_in        = amp_ff;
      neg_in        = neg_ff;
      num_in        = num_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready     = 1'b0;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_start_req) begin
                  frame_in  = '0;
                  phase_in  = '0;
                  active_in = 1'b1;
                  state_in  = ST_LOOKUP;
               end else if (active_ff) begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            // A zero length plays as one frame.
            len_in = (length_ff == '0) ? FRAME_W'(1) : length_ff;
            last_in = (frame_ff >= len_in - 1'b1);
            remain_in = (frame_ff < len_in) ? len_in - frame_ff : '0;
            state_in = ST_MUL_AMP;
         end
         ST_MUL_AMP: begin
            amp_in   = {{(AMP_W-MAG_W){1'b0}}, sine.mag} * {{(AMP_W-MAG_W){1'b0}}, AMP_Q16};
            neg_in   = sine.neg;
            state_in = ST_MUL_ENV;
         end
         ST_MUL_ENV: begin
            // Dropping the Q16 fraction first leaves the truncated quotient unchanged.
            num_in   = product[PROD_W-1:16];
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = neg_ff ? -{{(SAMPLE_W-QUOT_W){1'b0}}, quotient}
                                      :  {{(SAMPLE_W-QUOT_W){1'b0}}, quotient};
               rsp_last_in   = last_ff;
               frame_in      = frame_ff + 1'b1;
               phase_in      = phase_ff + step_ff;
               if (last_ff) begin
                  active_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= PHASE_STEP_RESET;
         length_ff    <= LENGTH_RESET;
         frame_ff     <= '0;
         phase_ff     <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         length_ff    <= length_in;
         frame_ff     <= frame_in;
         phase_ff     <= phase_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff        <= len_in;
      remain_ff     <= remain_in;
      last_ff       <= last_in;
      amp_ff        <= amp_in;
      neg_ff        <= neg_in;
      num_ff        <= num_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

// ----- hw/rtl/dsb_checker.sv -----
// ----------------------------------------------------------------------------
// Decaying sine beep generator checker
// Port-level assertions on the beep block, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "decaying_sine_beep_generator_defines.svh"

module dsb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_start_req,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [dsb_pkg::SAMPLE_W-1:0] rsp_sample,
   input logic                                rsp_last
);

   // A waiting sample must not change until it is taken.
   `DSB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last), "result changed while stalled")

   // A start tick always begins a computation, so the block is busy next.
   `DSB_ASSERT(a_start_busy, req_valid && req_ready && req_start_req |=> !req_ready, "start tick did not occupy the block")

   // A new sample only appears at the end of a computation.
   `DSB_ASSERT(a_rsp_after_busy, $rose(rsp_valid) |-> $past(!req_ready), "result appeared without a computation")

   // Reset leaves no result pending.
   `DSB_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind decaying_sine_beep_generator dsb_checker u_dsb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_start_req (req_start_req),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_sample    (rsp_sample),
   .rsp_last      (rsp_last)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying sine beep generator testbench
// Sends tick transfers with and without start, retunes the phase step and
// the tone length between bursts, and compares every sample and last flag
// with a cycle-free model of the tone, envelope and sine table.
// ----------------------------------------------------------------------------
module testbench;
   import dsb_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int BLOCK_LATENCY = 21;
   localparam int QUIET_LIMIT   = 3000;
   localparam int TICK_TARGET   = 1850;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } beep_result_type;

   class beep_scoreboard;
      bit [PHASE_W-1:0]  step_reg;
      bit [FRAME_W-1:0]  length_reg;
      bit [FRAME_W-1:0]  frame;
      bit [PHASE_W-1:0]  phase;
      bit                playing;
      int unsigned       quarter[TABLE_DEPTH + 1];
      beep_result_type   pending[$];
      int                errors;

      function new();
         for (int k = 0; k <= TABLE_DEPTH; k++)
            quarter[k] = quarter_wave(k);
         step_reg   = PHASE_STEP_RESET;
         length_reg = LENGTH_RESET;
         frame      = '0;
         phase      = '0;
         playing    = 1'b0;
         errors     = 0;
      endfunction

      // Q30 Taylor series of the sine, rounded into Q1.15.
      function int unsigned quarter_wave(int unsigned k);
         longint unsigned x, x2, term, v, n;
         longint          sum;
         x    = (HALF_PI_Q30 * k) / TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = $signed(x);
         for (n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n[0])
               sum -= $signed(term);
            else
               sum += $signed(term);
         end
         if (sum < 0)
            sum = 0;
         v = ($unsigned(sum) * FULL_Q15 + ROUND_Q30) >> 30;
         if (v > FULL_Q15)
            v = FULL_Q15;
         return v[31:0];
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_PHASE_STEP:    step_reg   = data;
            CSR_LENGTH_FRAMES: length_reg = data[FRAME_W-1:0];
         endcase
      endfunction

      // Advances the tone by one tick; returns 1 when the tick yields a sample.
      function bit note_tick(bit start);
         longint unsigned            len, remaining, idx, mag;
         int unsigned                level;
         bit                         fin;
         logic signed [SAMPLE_W-1:0] value;
         beep_result_type            r;
         if (start) begin
            frame   = '0;
            phase   = '0;
            playing = 1'b1;
         end
         if (!playing)
            return 1'b0;
         len = (length_reg == '0) ? 1 : length_reg;
         if (frame >= len - 1) begin
            fin       = 1'b1;
            remaining = (frame < len) ? len - frame : 0;
         end else begin
            fin       = 1'b0;
            remaining = len - frame;
         end
         idx = (64'(phase[PHASE_W-3:0]) * TABLE_DEPTH) >> 30;
         if (idx > TABLE_DEPTH)
            idx = TABLE_DEPTH;
         // Odd quadrants read the table backwards, the upper half is negated.
         level = phase[PHASE_W-2] ? quarter[TABLE_DEPTH - idx] : quarter[idx];
         mag   = (64'(level) * AMP_Q16 * remaining) / (len << 16);
         value = mag[SAMPLE_W-1:0];
         r.sample = phase[PHASE_W-1] ? -value : value;
         r.last   = fin;
         pending.push_back(r);
         frame = frame + 1'b1;
         phase = phase + step_reg;
         if (fin)
            playing = 1'b0;
         return 1'b1;
      endfunction

      function void check_sample(logic signed [SAMPLE_W-1:0] sample, logic fin);
         beep_result_type want;
         if (pending.size() == 0) begin
            $error("unexpected result: sample %0d last %0b", sample, fin);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (sample !== want.sample) begin
            $error("sample: expected %0d, actual %0d", want.sample, sample);
            errors++;
         end
         if (fin !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, fin);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_start_req = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       rsp_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   csr_index_type              csr_index = CSR_PHASE_STEP;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   beep_scoreboard board;
   bit             steady = 1'b0;
   int             sent = 0;
   int             quiet_cycles = 0;
   int             burst_no;

   decaying_sine_beep_generator #(
      .SINE_TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_start_req(req_start_req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_sample(rsp_sample),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_sample(rsp_sample, rsp_last);
         rsp_ready <= steady || ($urandom_range(99) >= 18);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // Valid is only lowered when a gap follows, so back-to-back transfers
   // never see two assignments in one step.
   task automatic send_tick(input bit start);
      while (!steady && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_start_req <= start;
      do @(posedge clock); while (!req_ready);
      void'(board.note_tick(start));
      sent++;
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, data);
   endtask

   // Waits for every sample to drain, then lets the divider finish off.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.outstanding() != 0);
      repeat (2 * BLOCK_LATENCY) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_step();
      case ($urandom_range(5))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom_range(32'h0400_0000);
         default: return $urandom();
      endcase
   endfunction

   // Upper data bits are random; only the low length bits should count.
   function automatic logic [CSR_DATA_W-1:0] pick_length();
      int unsigned roll;
      logic [FRAME_W-1:0] len;
      roll = $urandom_range(99);
      if (roll < 5)
         len = '0;
      else if (roll < 9)
         len = '1;
      else if (roll < 15)
         len = FRAME_W'($urandom_range(20'hFFFFF, 49));
      else
         len = FRAME_W'($urandom_range(48, 1));
      return {12'($urandom()), len};
   endfunction

   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Idle tick, then the reset tone with a restart while it plays.
      send_tick(1'b0);
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      send_tick(1'b1);
      repeat (2) send_tick(1'b0);
      settle();

      // Zero length behaves as a single-frame tone; top step wraps.
      write_csr(CSR_LENGTH_FRAMES, 32'h0);
      write_csr(CSR_PHASE_STEP, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_tick(1'b1);
      send_tick(1'b0);
      settle();

      write_csr(CSR_LENGTH_FRAMES, 32'd1);
      write_csr(CSR_PHASE_STEP, 32'h8000_0000);
      csr_valid <= 1'b0;
      send_tick(1'b1);
      send_tick(1'b0);
      settle();

      write_csr(CSR_LENGTH_FRAMES, 32'd3);
      write_csr(CSR_PHASE_STEP, 32'h4000_0000);
      csr_valid <= 1'b0;
      send_tick(1'b1);
      repeat (3) send_tick(1'b0);
      settle();

      // Quarter-turn steps visit the peaks; then the length is cut below
      // the current frame, which must end the tone on a silent sample.
      write_csr(CSR_LENGTH_FRAMES, 32'hFFFF_FFFF);
      csr_valid <= 1'b0;
      send_tick(1'b1);
      repeat (4) send_tick(1'b0);
      settle();
      write_csr(CSR_LENGTH_FRAMES, 32'd2);
      csr_valid <= 1'b0;
      repeat (2) send_tick(1'b0);

      burst_no = 0;
      while (sent < TICK_TARGET) begin
         settle();
         steady = (burst_no >= 20 && burst_no < 28);
         case ($urandom_range(4))
            0: write_csr(CSR_PHASE_STEP, pick_step());
            1: write_csr(CSR_LENGTH_FRAMES, pick_length());
            2: begin
               write_csr(CSR_PHASE_STEP, pick_step());
               write_csr(CSR_LENGTH_FRAMES, pick_length());
            end
            3: begin
               write_csr(CSR_LENGTH_FRAMES, pick_length());
               write_csr(CSR_PHASE_STEP, pick_step());
            end
            default: ;
         endcase
         csr_valid <= 1'b0;
         // A quarter of the bursts carry on with the tone already playing.
         if ($urandom_range(3) != 0)
            send_tick(1'b1);
         repeat ($urandom_range(60, 10))
            send_tick($urandom_range(99) < 4);
         burst_no++;
      end

      settle();
      if (board.errors == 0 && board.outstanding() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/dsb_pkg.sv
hw/rtl/dsb_sine_rom.sv
hw/rtl/dsb_divider.sv
hw/rtl/decaying_sine_beep_generator.sv
hw/rtl/dsb_checker.sv
tb/testbench.sv
